### rtl/sep_pkg.sv
// shared constants for the sieve eviction engine
package sep_pkg;
	localparam int unsigned DefEntries = 256;
	localparam int unsigned TagW = 48;
	localparam int unsigned SizeW = 32;
	localparam int unsigned KlenW = 8;
	localparam int unsigned TotalW = 41;

	localparam logic [1:0] ACT_TOUCH = 2'd0;
	localparam logic [1:0] ACT_ADD = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;
	localparam logic [1:0] ACT_EVICT = 2'd3;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;
endpackage

### rtl/sieve_eviction_policy.sv
// top level of the sieve eviction engine
// A request transfer happens when start is high and busy is low; exactly one
// result follows, marked by done for one cycle in which busy is already low,
// and the receiver cannot stall it. Tag, size, key length and the list links
// live in one ram with registered read; occupied and visited marks are
// flip-flops cleared at reset, so the table starts empty. Lookups walk the
// slots in order, one per cycle, and stop at the key: touch and update end
// there, remove then unlinks the entry from the list, a miss walks every slot,
// and an add that inserts puts the key in the lowest free slot as the newest
// entry. Evict walks the list from the hand (from the oldest entry when the
// hand is not on an occupied slot), one slot per cycle, and clears each visited
// mark it meets (at most ENTRIES); on an empty table it goes straight to its
// result with status empty. The result shows in the first cycle with busy
// low, and the next request can be taken at the end of that same cycle.
module sieve_eviction_policy #(
	parameter int unsigned ENTRIES = sep_pkg::DefEntries
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     action,
	input  logic [sep_pkg::TagW-1:0]       key_tag,
	input  logic [sep_pkg::KlenW-1:0]      key_length,
	input  logic [sep_pkg::SizeW-1:0]      entry_size,
	output logic                           done,
	output logic [1:0]                     status,
	output logic [sep_pkg::TagW-1:0]       victim_tag,
	output logic [sep_pkg::TotalW-1:0]     bytes_in_use
);
	import sep_pkg::*;

	localparam int unsigned AW = $clog2(ENTRIES);
	localparam int unsigned PW = AW + 1;
	localparam logic [PW-1:0] NONE = PW'(ENTRIES);
	localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);
	localparam int unsigned RW = TagW + SizeW + KlenW + 2 * PW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_EVCK = 3'd2;
	localparam logic [2:0] S_LINK = 3'd3;
	localparam logic [2:0] S_FIXN = 3'd4;
	localparam logic [2:0] S_FIXO = 3'd5;
	localparam logic [2:0] S_RESP = 3'd6;

	logic [2:0] state_q;
	logic [1:0] act_q;
	logic [TagW-1:0] tag_q;
	logic [KlenW-1:0] klen_q;
	logic [SizeW-1:0] size_q;
	logic [ENTRIES-1:0] occ_q, vis_q;
	logic [PW-1:0] newest_q, oldest_q, hand_q;
	logic [TotalW-1:0] total_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] slot_q;
	logic [1:0] st_q;
	logic [TagW-1:0] vict_q;
	logic [PW-1:0] s_old_q, s_new_q;

	// ram word: tag, size, key length, older, newer
	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [RW-1:0] wdata, rdata;
	logic [TagW-1:0] r_tag;
	logic [SizeW-1:0] r_size;
	logic [KlenW-1:0] r_klen;
	logic [PW-1:0] r_old, r_new;

	assign {r_tag, r_size, r_klen, r_old, r_new} = rdata;

	sep_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// lowest free slot
	logic [AW-1:0] free_idx;
	logic full;
	always_comb begin
		free_idx = '0;
		full = 1'b1;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!occ_q[i]) begin
				free_idx = AW'(i);
				full = 1'b0;
			end
		end
	end

	logic [AW-1:0] start_slot;
	assign start_slot = (hand_q != NONE && occ_q[hand_q[AW-1:0]]) ?
		hand_q[AW-1:0] : oldest_q[AW-1:0];

	// tag match on the word of slot idx_q, end of walk, evict successor
	logic hit, scan_end;
	logic [AW-1:0] next_slot;
	assign hit = occ_q[idx_q] && (r_tag == tag_q);
	assign scan_end = (idx_q == LAST);
	assign next_slot = (r_new == NONE) ? oldest_q[AW-1:0] : r_new[AW-1:0];

	assign busy = (state_q != S_IDLE);

	// read address and write port
	always_comb begin
		raddr = '0;
		we = 1'b0;
		waddr = slot_q;
		wdata = rdata;
		unique case (state_q)
			S_IDLE: begin
				raddr = (action == ACT_EVICT) ? start_slot : '0;
			end
			S_SCAN: begin
				raddr = idx_q + 1'b1;
				if (hit) begin
					if (act_q == ACT_ADD) begin
						we = 1'b1;
						waddr = idx_q;
						wdata = {r_tag, size_q, klen_q, r_old, r_new};
					end else if (act_q == ACT_REMOVE) begin
						raddr = r_new[AW-1:0];
					end
				end else if (scan_end && act_q == ACT_ADD && !full) begin
					we = 1'b1;
					waddr = free_idx;
					wdata = {tag_q, size_q, klen_q, newest_q, NONE};
					raddr = newest_q[AW-1:0];
				end
			end
			S_EVCK: begin
				raddr = vis_q[slot_q] ? next_slot : r_new[AW-1:0];
			end
			// old newest entry now points at the new one
			S_LINK: begin
				we = 1'b1;
				waddr = s_old_q[AW-1:0];
				wdata = {r_tag, r_size, r_klen, r_old, s_new_q};
			end
			// unlink: newer neighbor first, then the older one
			S_FIXN: begin
				we = (s_new_q != NONE);
				waddr = s_new_q[AW-1:0];
				wdata = {r_tag, r_size, r_klen, s_old_q, r_new};
				raddr = s_old_q[AW-1:0];
			end
			S_FIXO: begin
				we = (s_old_q != NONE);
				waddr = s_old_q[AW-1:0];
				wdata = {r_tag, r_size, r_klen, r_old, s_new_q};
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			act_q <= ACT_TOUCH;
			tag_q <= '0;
			klen_q <= '0;
			size_q <= '0;
			occ_q <= '0;
			vis_q <= '0;
			newest_q <= NONE;
			oldest_q <= NONE;
			hand_q <= NONE;
			total_q <= '0;
			idx_q <= '0;
			slot_q <= '0;
			st_q <= ST_DONE;
			vict_q <= '0;
			s_old_q <= NONE;
			s_new_q <= NONE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						act_q <= action;
						tag_q <= key_tag;
						klen_q <= key_length;
						size_q <= entry_size;
						vict_q <= '0;
						st_q <= ST_DONE;
						idx_q <= '0;
						if (action == ACT_EVICT) begin
							if (oldest_q == NONE) begin
								st_q <= ST_EMPTY;
								state_q <= S_RESP;
							end else begin
								slot_q <= start_slot;
								state_q <= S_EVCK;
							end
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				// tag match walk: word for idx_q is on rdata
				S_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (hit) begin
						if (act_q == ACT_TOUCH) begin
							vis_q[idx_q] <= 1'b1;
							state_q <= S_RESP;
						end else if (act_q == ACT_ADD) begin
							total_q <= total_q - TotalW'(r_klen) - TotalW'(r_size)
								+ TotalW'(klen_q) + TotalW'(size_q);
							state_q <= S_RESP;
						end else begin
							if (hand_q == {1'b0, idx_q}) begin
								hand_q <= r_new;
							end
							total_q <= total_q - TotalW'(r_klen) - TotalW'(r_size);
							occ_q[idx_q] <= 1'b0;
							vis_q[idx_q] <= 1'b0;
							s_old_q <= r_old;
							s_new_q <= r_new;
							if (r_new == NONE) newest_q <= r_old;
							if (r_old == NONE) oldest_q <= r_new;
							state_q <= S_FIXN;
						end
					end else if (scan_end) begin
						if (act_q == ACT_ADD && !full) begin
							occ_q[free_idx] <= 1'b1;
							vis_q[free_idx] <= 1'b0;
							total_q <= total_q + TotalW'(klen_q) + TotalW'(size_q);
							if (oldest_q == NONE) begin
								oldest_q <= {1'b0, free_idx};
							end
							newest_q <= {1'b0, free_idx};
							s_old_q <= newest_q;
							s_new_q <= {1'b0, free_idx};
							state_q <= (newest_q == NONE) ? S_RESP : S_LINK;
						end else begin
							st_q <= (act_q == ACT_ADD) ? ST_FULL : ST_ABSENT;
							state_q <= S_RESP;
						end
					end
				end
				// evict walk: word for slot_q is on rdata
				S_EVCK: begin
					if (vis_q[slot_q]) begin
						vis_q[slot_q] <= 1'b0;
						slot_q <= next_slot;
					end else begin
						hand_q <= r_new;
						vict_q <= r_tag;
						total_q <= total_q - TotalW'(r_klen) - TotalW'(r_size);
						occ_q[slot_q] <= 1'b0;
						vis_q[slot_q] <= 1'b0;
						s_old_q <= r_old;
						s_new_q <= r_new;
						if (r_new == NONE) newest_q <= r_old;
						if (r_old == NONE) oldest_q <= r_new;
						state_q <= S_FIXN;
					end
				end
				S_LINK: begin
					state_q <= S_RESP;
				end
				S_FIXN: begin
					state_q <= S_FIXO;
				end
				S_FIXO: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign status = st_q;
	assign victim_tag = vict_q;
	assign bytes_in_use = total_q;

	// result strobe, handshake, list end and known-value checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy);
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done);
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy);
	a_ends_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(oldest_q == NONE) == (newest_q == NONE));
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown({status, victim_tag, bytes_in_use}));
endmodule

### rtl/sep_ram.sv
// generic single-port-write, single-read ram with registered read
module sep_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### dv/sieve_eviction_policy_tb.sv
// self-checking testbench for the sieve eviction engine
`timescale 1ns / 1ps

module sieve_eviction_policy_tb;
	import sep_pkg::*;

	localparam int unsigned NumSlots = DefEntries;
	localparam int unsigned NoSlot = NumSlots;
	localparam int unsigned PoolMax = 320;
	localparam longint unsigned CycleLimit = 4000000;

	typedef struct packed {
		logic [1:0]        status;
		logic [TagW-1:0]   victim;
		logic [TotalW-1:0] total;
	} cache_result_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [1:0]          action;
	logic [TagW-1:0]     key_tag;
	logic [KlenW-1:0]    key_length;
	logic [SizeW-1:0]    entry_size;
	logic                done;
	logic [1:0]          status;
	logic [TagW-1:0]     victim_tag;
	logic [TotalW-1:0]   bytes_in_use;

	// shadow copy of the slot table
	logic [TagW-1:0]   pr_tag[NumSlots];
	logic [SizeW-1:0]  pr_size[NumSlots];
	logic [KlenW-1:0]  pr_klen[NumSlots];
	bit                pr_visited[NumSlots];
	bit                pr_occupied[NumSlots];
	int unsigned       pr_older[NumSlots];
	int unsigned       pr_newer[NumSlots];
	int unsigned       pr_newest;
	int unsigned       pr_oldest;
	int unsigned       pr_hand;
	logic [TotalW-1:0] pr_total;

	cache_result_t   expected_q[$];
	logic [TagW-1:0] tag_pool[PoolMax];
	int              error_count;
	longint unsigned cycle_count;
	bit              no_idle;

	sieve_eviction_policy uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .key_tag(key_tag), .key_length(key_length),
		.entry_size(entry_size), .done(done), .status(status),
		.victim_tag(victim_tag), .bytes_in_use(bytes_in_use)
	);

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("%0t timeout", $time);
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int unsigned find_slot(logic [TagW-1:0] tag);
		for (int i = 0; i < NumSlots; i++)
			if (pr_occupied[i] && pr_tag[i] == tag) return i;
		return NoSlot;
	endfunction

	function automatic int unsigned lowest_free();
		for (int i = 0; i < NumSlots; i++)
			if (!pr_occupied[i]) return i;
		return NoSlot;
	endfunction

	// unlink a slot and take its bytes off the total
	function automatic void unlink_slot(int unsigned s);
		int unsigned o;
		int unsigned n;
		o = pr_older[s];
		n = pr_newer[s];
		pr_total = pr_total - pr_klen[s] - pr_size[s];
		if (n < NoSlot) pr_older[n] = o;
		else pr_newest = o;
		if (o < NoSlot) pr_newer[o] = n;
		else pr_oldest = n;
		pr_occupied[s] = 0;
		pr_visited[s] = 0;
	endfunction

	// apply one request to the shadow table and return its result
	function automatic cache_result_t sieve_apply(logic [1:0] act, logic [TagW-1:0] tag,
			logic [KlenW-1:0] klen, logic [SizeW-1:0] size);
		cache_result_t r;
		int unsigned s;
		int unsigned guard;
		r = '0;
		r.status = ST_DONE;
		case (act)
			ACT_TOUCH: begin
				s = find_slot(tag);
				if (s < NoSlot) pr_visited[s] = 1;
				else r.status = ST_ABSENT;
			end
			ACT_ADD: begin
				s = find_slot(tag);
				if (s < NoSlot) begin
					pr_total = pr_total - pr_klen[s] - pr_size[s] + klen + size;
					pr_klen[s] = klen;
					pr_size[s] = size;
				end else begin
					s = lowest_free();
					if (s < NoSlot) begin
						pr_tag[s] = tag;
						pr_klen[s] = klen;
						pr_size[s] = size;
						pr_visited[s] = 0;
						pr_occupied[s] = 1;
						pr_older[s] = pr_newest;
						pr_newer[s] = NoSlot;
						if (pr_newest < NoSlot) pr_newer[pr_newest] = s;
						pr_newest = s;
						if (pr_oldest >= NoSlot) pr_oldest = s;
						pr_total = pr_total + klen + size;
					end else r.status = ST_FULL;
				end
			end
			ACT_REMOVE: begin
				s = find_slot(tag);
				if (s < NoSlot) begin
					if (pr_hand == s) pr_hand = pr_newer[s];
					unlink_slot(s);
				end else r.status = ST_ABSENT;
			end
			default: begin
				if (pr_oldest >= NoSlot) r.status = ST_EMPTY;
				else begin
					guard = 0;
					s = (pr_hand < NoSlot && pr_occupied[pr_hand]) ? pr_hand : pr_oldest;
					// clear visited marks, wrapping at the newest end
					while (pr_visited[s] && guard <= 2 * NumSlots) begin
						pr_visited[s] = 0;
						s = pr_newer[s];
						if (s >= NoSlot) s = pr_oldest;
						guard++;
					end
					pr_hand = pr_newer[s];
					r.victim = pr_tag[s];
					unlink_slot(s);
				end
			end
		endcase
		r.total = pr_total;
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		cache_result_t e;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				$display("%0t unexpected result: status %0d victim %h bytes %0d", $time,
					status, victim_tag, bytes_in_use);
				error_count++;
			end else begin
				e = expected_q.pop_front();
				if (status !== e.status) begin
					$display("%0t status: expected %0d actual %0d", $time, e.status, status);
					error_count++;
				end
				if (victim_tag !== e.victim) begin
					$display("%0t victim_tag: expected %h actual %h", $time, e.victim,
						victim_tag);
					error_count++;
				end
				if (bytes_in_use !== e.total) begin
					$display("%0t bytes_in_use: expected %0d actual %0d", $time, e.total,
						bytes_in_use);
					error_count++;
				end
			end
		end
	end

	// one request transfer, then a random gap unless no_idle is set
	task automatic send_request(logic [1:0] act, logic [TagW-1:0] tag,
			logic [KlenW-1:0] klen, logic [SizeW-1:0] size);
		int gap;
		start <= 1'b1;
		action <= act;
		key_tag <= tag;
		key_length <= klen;
		entry_size <= size;
		do @(posedge clk); while (busy);
		expected_q.push_back(sieve_apply(act, tag, klen, size));
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic [SizeW-1:0] pick_size();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		logic [TagW-1:0] t_max;
		logic [TagW-1:0] t_mid;
		t_max = '1;
		t_mid = 48'h5a5a_a5a5_0f0f;
		no_idle = 0;
		// empty table cases
		send_request(ACT_EVICT, 0, 0, 0);
		send_request(ACT_TOUCH, t_max, 8'hff, 0);
		send_request(ACT_REMOVE, 0, 0, 0);
		// adds at the extremes, then updates of a present key
		send_request(ACT_ADD, 0, 0, 0);
		send_request(ACT_ADD, t_max, 8'hff, 32'hffff_ffff);
		send_request(ACT_ADD, t_mid, 8'h80, 32'h8000_0000);
		send_request(ACT_ADD, t_max, 8'h01, 32'h0000_0001);
		send_request(ACT_ADD, t_max, 8'hff, 32'hffff_ffff);
		// visited marks steer the scan
		send_request(ACT_TOUCH, 0, 0, 0);
		send_request(ACT_TOUCH, t_max, 0, 0);
		send_request(ACT_EVICT, 0, 0, 0);
		send_request(ACT_ADD, 48'h1, 8'h10, 32'h100);
		send_request(ACT_TOUCH, 48'h1, 0, 0);
		send_request(ACT_TOUCH, t_max, 0, 0);
		// removes and evicts down to an empty table; one scan wraps past the newest end
		send_request(ACT_REMOVE, t_max, 0, 0);
		send_request(ACT_EVICT, 0, 0, 0);
		send_request(ACT_REMOVE, t_mid, 0, 0);
		send_request(ACT_EVICT, 0, 0, 0);
		send_request(ACT_EVICT, 0, 0, 0);
		send_request(ACT_EVICT, 0, 0, 0);
		drain_results();
	endtask

	// fill every slot, then add one more to a full table
	task automatic test_full_table();
		no_idle = 1;
		for (int i = 0; i <= NumSlots; i++)
			send_request(ACT_ADD, {$urandom, 16'(i)}, 8'($urandom), pick_size());
		send_request(ACT_TOUCH, 48'h0, 0, 0);
		send_request(ACT_EVICT, 0, 0, 0);
		send_request(ACT_ADD, 48'hffff_0000_ffff, 8'h7f, 32'h1234_5678);
		// sender holds off until everything has come back
		drain_results();
		no_idle = 0;
		for (int i = 0; i < 40; i++) send_request(ACT_EVICT, 0, 0, 0);
		drain_results();
	endtask

	task automatic test_random(int count, int pool_size);
		int w;
		logic [1:0] act;
		logic [TagW-1:0] tag;
		for (int i = 0; i < pool_size; i++)
			tag_pool[i] = {16'($urandom), 32'($urandom)};
		tag_pool[0] = '0;
		tag_pool[1] = '1;
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
			w = $urandom_range(0, 99);
			if (w < 30) act = ACT_TOUCH;
			else if (w < 62) act = ACT_ADD;
			else if (w < 77) act = ACT_REMOVE;
			else act = ACT_EVICT;
			if ($urandom_range(0, 9) == 0) tag = {16'($urandom), 32'($urandom)};
			else tag = tag_pool[$urandom_range(0, pool_size - 1)];
			send_request(act, tag, 8'($urandom), pick_size());
		end
		drain_results();
	endtask

	initial begin
		error_count = 0;
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_TOUCH;
		key_tag = '0;
		key_length = '0;
		entry_size = '0;
		pr_newest = NoSlot;
		pr_oldest = NoSlot;
		pr_hand = NoSlot;
		pr_total = '0;
		for (int i = 0; i < NumSlots; i++) begin
			pr_visited[i] = 0;
			pr_occupied[i] = 0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_table();
		test_random(1100, 48);
		test_random(450, PoolMax);

		drain_results();
		repeat (1200) @(posedge clk);
		if (error_count == 0 && expected_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
